>>> sv/bb3_pkg.sv
package bb3_pkg;

  localparam int LINE_WIDTH   = 640;
  localparam int FRAME_HEIGHT = 480;

  localparam int COL_W = $clog2(LINE_WIDTH);
  // Row counter also covers the two flush rows below the frame.
  localparam int ROW_W = $clog2(FRAME_HEIGHT + 2);

  localparam int CH_W   = 8;
  localparam int PIX_W  = 3 * CH_W;
  localparam int TAPS   = 9;
  localparam int SUM_W  = 12;

  // floor(x / 9) == (x * 3641) >> 15 for every x below 32768
  localparam int          DIV9_SHIFT = 15;
  localparam logic [11:0] DIV9_MUL   = 12'd3641;

  typedef logic [PIX_W-1:0] pixel_t;

endpackage

>>> sv/box_blur_3x3_rgb.sv
// Channel | Direction | tdata (low bit up)        | tuser / tlast
// in_     | slave     | red_in, green_in, blue_in | tuser: flush
// out_    | master    | red_out, green_out, blue_out | tlast: frame_last
//
// One item per cycle sustained while the result register is not stalled; a
// result passes the line store read register, then the result register.
// Each result belongs to the pixel one row and one column behind the input.
// rst_n (synchronous, low) clears position, window and valid flags; line
// stores are not cleared, unwritten entries are masked at the frame edge.
// A stalled result register holds the item in stage 1, which drops in_tready.
module box_blur_3x3_rgb
  import bb3_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red_in, green_in, blue_in
  input  logic [0:0]  in_tuser,   // flush
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // red_out, green_out, blue_out
  output logic        out_tlast
);

  logic             in_acc;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  logic             s1_valid_r, s1_valid_nxt;
  logic [COL_W-1:0] s1_col_r;
  logic [ROW_W-1:0] s1_row_r;
  pixel_t           s1_pix_r;
  logic             s1_adv;

  pixel_t           upper_rd, middle_rd;
  pixel_t           win_r [3][3];
  pixel_t           fresh [3];
  pixel_t           taps  [TAPS];
  pixel_t           avg;
  logic [2:0]       row_en;
  logic             col_first, col_second, s1_emit, s1_last;

  logic             out_valid_r;
  pixel_t           out_data_r;
  logic             out_last_r;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  // position of the next item
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (col_r == '0 && row_r >= ROW_W'(FRAME_HEIGHT + 1)) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (col_r == COL_W'(LINE_WIDTH - 1)) begin
      col_nxt = '0;
      row_nxt = row_r + ROW_W'(1);
    end else begin
      col_nxt = col_r + COL_W'(1);
    end
  end

  assign s1_valid_nxt = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (in_acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_col_r <= col_r;
      s1_row_r <= row_r;
      s1_pix_r <= in_tuser[0] ? '0 : pixel_t'(in_tdata);
    end
  end

  bb3_ram #(.WIDTH(PIX_W), .DEPTH(LINE_WIDTH)) u_upper (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_col_r),
    .wr_data (middle_rd),
    .rd_en   (in_acc),
    .rd_addr (col_r),
    .rd_data (upper_rd)
  );

  bb3_ram #(.WIDTH(PIX_W), .DEPTH(LINE_WIDTH)) u_middle (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_col_r),
    .wr_data (s1_pix_r),
    .rd_en   (in_acc),
    .rd_addr (col_r),
    .rd_data (middle_rd)
  );

  // First column finishes the previous row from the old window; other
  // columns center one row up and one column left in the shifted window.
  always_comb begin
    col_first  = (s1_col_r == '0);
    col_second = (s1_col_r == COL_W'(1));
    fresh[0]   = upper_rd;
    fresh[1]   = middle_rd;
    fresh[2]   = s1_pix_r;
    if (col_first) begin
      row_en  = {s1_row_r <= ROW_W'(FRAME_HEIGHT), 1'b1, s1_row_r >= ROW_W'(3)};
      s1_emit = (s1_row_r >= ROW_W'(2));
    end else begin
      row_en  = {s1_row_r < ROW_W'(FRAME_HEIGHT), 1'b1, s1_row_r >= ROW_W'(2)};
      s1_emit = (s1_row_r >= ROW_W'(1)) && (s1_row_r <= ROW_W'(FRAME_HEIGHT));
    end
    s1_last = col_first && (s1_row_r == ROW_W'(FRAME_HEIGHT + 1));
    for (int i = 0; i < 3; i++) begin
      if (col_first) begin
        taps[i*3]     = '0;
        taps[i*3 + 1] = win_r[i][1];
        taps[i*3 + 2] = win_r[i][2];
      end else begin
        taps[i*3]     = col_second ? '0 : win_r[i][1];
        taps[i*3 + 1] = win_r[i][2];
        taps[i*3 + 2] = fresh[i];
      end
      if (!row_en[i]) begin
        taps[i*3]     = '0;
        taps[i*3 + 1] = '0;
        taps[i*3 + 2] = '0;
      end
    end
  end

  bb3_avg u_avg (
    .taps (taps),
    .avg  (avg)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else if (s1_adv) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i][0] <= win_r[i][1];
        win_r[i][1] <= win_r[i][2];
        win_r[i][2] <= fresh[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit) begin
      out_data_r <= avg;
      out_last_r <= s1_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |-> !in_tready)
    else $error("item taken while stage 1 is stalled");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= COL_W'(LINE_WIDTH - 1))
    else $error("column counter beyond line width");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= ROW_W'(FRAME_HEIGHT + 1))
    else $error("row counter beyond flush rows");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && col_r == '0 && row_r == ROW_W'(FRAME_HEIGHT + 1))
      |=> (col_r == '0 && row_r == '0))
    else $error("position did not return to frame start");

  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_last) |=> (out_tvalid && out_tlast))
    else $error("frame end result not loaded");
`endif

endmodule

>>> sv/bb3_ram.sv
module bb3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 640
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/bb3_avg.sv
module bb3_avg
  import bb3_pkg::*;
(
  input  pixel_t taps [TAPS],
  output pixel_t avg
);

  logic [SUM_W-1:0]         sum  [3];
  logic [SUM_W+12-1:0]      prod [3];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = '0;
      for (int t = 0; t < TAPS; t++) begin
        sum[ch] = sum[ch] + SUM_W'(taps[t][ch*CH_W +: CH_W]);
      end
      // divide by nine through the reciprocal
      prod[ch] = (SUM_W + 12)'(sum[ch]) * (SUM_W + 12)'(DIV9_MUL);
      avg[ch*CH_W +: CH_W] = prod[ch][DIV9_SHIFT +: CH_W];
    end
  end

endmodule

>>> verif/box_blur_3x3_rgb_test.sv
module box_blur_3x3_rgb_test;
  import bb3_pkg::*;

  typedef struct packed {
    logic            last;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } blur_t;

  typedef struct packed {
    logic   flush;
    pixel_t px;
  } stim_t;

  typedef enum int {PACE_NONE, PACE_LIGHT, PACE_FULL} pace_e;

  localparam int     RANDOM_ITEMS     = 1050;
  localparam int     FLUSH_IN_FRAME   = 5;
  localparam int     DRAIN_CYCLES     = 16;
  localparam longint CYCLE_LIMIT      = 64'd400_000;

  // Start of the frame's first row: channel extremes, flush inside the frame with
  // live data that must be ignored, and white runs for saturated sums.
  localparam int OPENING_LEN = 20;
  localparam stim_t OPENING [OPENING_LEN] = '{
    '{1'b0, 24'h000000}, '{1'b0, 24'hFFFFFF}, '{1'b0, 24'h0000FF},
    '{1'b0, 24'h00FF00}, '{1'b0, 24'hFF0000}, '{1'b0, 24'hFFFFFF},
    '{1'b0, 24'hFFFFFF}, '{1'b1, 24'hFFFFFF}, '{1'b0, 24'hFFFFFF},
    '{1'b0, 24'h5A5A5A}, '{1'b0, 24'hA5A5A5}, '{1'b0, 24'h010203},
    '{1'b0, 24'hFEFDFC}, '{1'b0, 24'hFFFFFF}, '{1'b0, 24'hFFFFFF},
    '{1'b0, 24'hFFFFFF}, '{1'b0, 24'h000000}, '{1'b1, 24'hABCDEF},
    '{1'b0, 24'h7F7F7F}, '{1'b0, 24'h808080}
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [23:0] in_tdata   = '0;
  logic [0:0]  in_tuser   = '0;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [23:0] out_tdata;
  logic        out_tlast;

  // Shadow of the block: line stores, window and raster position.
  pixel_t upper_store  [LINE_WIDTH] = '{default: '0};
  pixel_t middle_store [LINE_WIDTH] = '{default: '0};
  pixel_t win [3][3] = '{default: '0};
  int     col_pos = 0;
  int     row_pos = 0;

  blur_t  pending_blur [$];
  int     fail_count  = 0;
  pace_e  pace        = PACE_FULL;
  int     stall_left  = 0;
  longint cycle_count = 0;

  box_blur_3x3_rgb u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #2 clk = ~clk;

  function automatic bit row_in_frame(int r);
    return r >= 0 && r < FRAME_HEIGHT;
  endfunction

  function automatic void add_pixel(pixel_t p, ref int sum [3]);
    for (int ch = 0; ch < 3; ch++) sum[ch] += p[ch*CH_W +: CH_W];
  endfunction

  function automatic blur_t average_of(int sum [3], logic last);
    blur_t res;
    res.red   = CH_W'(sum[0] / TAPS);
    res.green = CH_W'(sum[1] / TAPS);
    res.blue  = CH_W'(sum[2] / TAPS);
    res.last  = last;
    return res;
  endfunction

  // Advance the shadow by one item; return 1 when the item releases a result.
  function automatic bit box_average_step(pixel_t px_in, logic fl, output blur_t res);
    pixel_t px;
    int     sum [3];
    int     c;
    int     r;
    int     j0;
    bit     emits;
    c     = col_pos;
    r     = row_pos;
    px    = fl ? '0 : px_in;
    sum   = '{0, 0, 0};
    emits = 1'b0;
    res   = '0;
    // First column closes the last pixel of the row two above; its right
    // neighbour is off the frame.
    if (c == 0 && r >= 2) begin
      for (int i = 0; i < 3; i++)
        if (row_in_frame(r - 3 + i)) begin
          add_pixel(win[i][1], sum);
          add_pixel(win[i][2], sum);
        end
      res   = average_of(sum, r - 2 == FRAME_HEIGHT - 1);
      emits = 1'b1;
    end
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2]       = upper_store[c];
    win[1][2]       = middle_store[c];
    win[2][2]       = px;
    upper_store[c]  = middle_store[c];
    middle_store[c] = px;
    if (c >= 1 && r >= 1 && r - 1 < FRAME_HEIGHT) begin
      j0 = (c == 1) ? 1 : 0;
      for (int i = 0; i < 3; i++)
        if (row_in_frame(r - 2 + i))
          for (int j = j0; j < 3; j++) add_pixel(win[i][j], sum);
      res   = average_of(sum, 1'b0);
      emits = 1'b1;
    end
    if (c == 0 && r >= FRAME_HEIGHT + 1) begin
      col_pos = 0;
      row_pos = 0;
    end else if (c + 1 >= LINE_WIDTH) begin
      col_pos = 0;
      row_pos = r + 1;
    end else begin
      col_pos = c + 1;
    end
    return emits;
  endfunction

  // Mostly back to back, a few short gaps, now and then a long one.
  function automatic int draw_gap(pace_e p);
    int pick;
    pick = $urandom_range(0, 99);
    case (p)
      PACE_FULL: begin
        if (pick < 55) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
      end
      PACE_LIGHT: return (pick < 94) ? 0 : $urandom_range(1, 2);
      default: return 0;
    endcase
  endfunction

  function automatic void draw_item(int flush_pct, output pixel_t px, output logic fl);
    int pick;
    pick = $urandom_range(0, 99);
    fl   = $urandom_range(0, 99) < flush_pct;
    if (pick < 15)      px = '1;
    else if (pick < 30) px = '0;
    else if (pick < 40) px = pixel_t'(8'hFF) << (CH_W * $urandom_range(0, 2));
    else                px = pixel_t'($urandom);
  endfunction

  // Called at a falling edge; returns at the falling edge after the handshake.
  task automatic send_item(pixel_t px, logic fl);
    int    gap;
    blur_t res;
    gap = draw_gap(pace);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    in_tuser  <= fl;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (box_average_step(px, fl, res)) pending_blur.push_back(res);
    @(negedge clk);
  endtask

  task automatic random_items(int n, int flush_pct, bit bulk);
    pixel_t px;
    logic   fl;
    for (int k = 0; k < n; k++) begin
      if (bulk && k % 1024 == 0)
        pace = ($urandom_range(0, 3) == 0) ? PACE_NONE : PACE_LIGHT;
      else if (!bulk && k % 64 == 0)
        pace = pace_e'($urandom_range(0, 2));
      draw_item(flush_pct, px, fl);
      send_item(px, fl);
    end
  endtask

  task automatic compare_field(string what, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      fail_count++;
    end
  endtask

  always @(negedge clk) begin
    if (stall_left == 0) stall_left = draw_gap(pace);
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    blur_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_blur.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, actual %h last %b",
                 $time, out_tdata, out_tlast);
        fail_count++;
      end else begin
        want = pending_blur.pop_front();
        compare_field("red",   want.red,   out_tdata[7:0]);
        compare_field("green", want.green, out_tdata[15:8]);
        compare_field("blue",  want.blue,  out_tdata[23:16]);
        compare_field("last",  8'(want.last), 8'(out_tlast));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("box_blur_3x3_rgb_test NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    pace = PACE_FULL;
    for (int k = 0; k < OPENING_LEN; k++) send_item(OPENING[k].px, OPENING[k].flush);

    // Run into the second row so results are in flight at the pause.
    random_items(RANDOM_ITEMS - RANDOM_ITEMS / 4, FLUSH_IN_FRAME, 1'b0);
    // Hold off until every result in flight has drained.
    in_tvalid <= 1'b0;
    while (pending_blur.size() != 0) @(negedge clk);
    @(negedge clk);
    random_items(RANDOM_ITEMS / 4, FLUSH_IN_FRAME, 1'b0);
    in_tvalid <= 1'b0;

    while (pending_blur.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("box_blur_3x3_rgb_test OK");
    end else begin
      $display("box_blur_3x3_rgb_test NOT OK");
    end
    $finish;
  end

endmodule
